FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, checked out of reset.
`define KF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the next cycle.
`define KF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/kf_pkg.sv
// ----------------------------------------------------------------------------
// kf_pkg
// Types, codes and microcode table of the fixed-point Kalman filter step.
// ----------------------------------------------------------------------------
package kf_pkg;

    localparam int ACC_W     = 52;
    localparam int MEM_DEPTH = 27;
    localparam int STEP_W    = 6;

    typedef logic [4:0] vaddr_t;
    typedef logic [STEP_W-1:0] step_t;

    // Scratch memory map
    localparam vaddr_t V_EST0  = 5'd0;
    localparam vaddr_t V_EST1  = 5'd1;
    localparam vaddr_t V_COV0  = 5'd2;
    localparam vaddr_t V_COV1  = 5'd3;
    localparam vaddr_t V_COV2  = 5'd4;
    localparam vaddr_t V_COV3  = 5'd5;
    localparam vaddr_t V_XP0   = 5'd6;
    localparam vaddr_t V_XP1   = 5'd7;
    localparam vaddr_t V_AP0   = 5'd8;
    localparam vaddr_t V_AP1   = 5'd9;
    localparam vaddr_t V_AP2   = 5'd10;
    localparam vaddr_t V_AP3   = 5'd11;
    localparam vaddr_t V_PP0   = 5'd12;
    localparam vaddr_t V_PP1   = 5'd13;
    localparam vaddr_t V_PP2   = 5'd14;
    localparam vaddr_t V_PP3   = 5'd15;
    localparam vaddr_t V_PC0   = 5'd16;
    localparam vaddr_t V_PC1   = 5'd17;
    localparam vaddr_t V_S     = 5'd18;
    localparam vaddr_t V_INV   = 5'd19;
    localparam vaddr_t V_K0    = 5'd20;
    localparam vaddr_t V_K1    = 5'd21;
    localparam vaddr_t V_INNOV = 5'd22;
    localparam vaddr_t V_M0    = 5'd23;
    localparam vaddr_t V_M1    = 5'd24;
    localparam vaddr_t V_M2    = 5'd25;
    localparam vaddr_t V_M3    = 5'd26;

    localparam step_t LAST_STEP = 6'd55;

    // Configuration register indexes
    localparam logic [2:0] CFG_A_MATRIX  = 3'd0;
    localparam logic [2:0] CFG_B_AND_C   = 3'd1;
    localparam logic [2:0] CFG_Q_MATRIX  = 3'd2;
    localparam logic [2:0] CFG_P_INITIAL = 3'd3;
    localparam logic [2:0] CFG_R_NOISE   = 3'd4;
    localparam logic [2:0] CFG_TIME_STEP = 3'd5;

    typedef enum logic [1:0] {
        CMD_INIT_FIELDS = 2'd0,
        CMD_INIT_ZERO   = 2'd1,
        CMD_UPDATE      = 2'd2,
        CMD_NOP         = 2'd3
    } cmd_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_INIT  = 9'b000000010,
        ST_READ  = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_ACC   = 9'b000010000,
        ST_STORE = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_INV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    // First multiplier operand
    typedef enum logic [3:0] {
        AS_A0, AS_A1, AS_A2, AS_A3,
        AS_B0, AS_B1, AS_C0, AS_C1,
        AS_Q0, AS_Q1, AS_Q2, AS_Q3,
        AS_R, AS_UNIT, AS_MEM
    } asrc_t;

    // Second multiplier operand
    typedef enum logic [1:0] {
        BS_MEM, BS_U, BS_Y, BS_ONE
    } bsrc_t;

    localparam logic [3:0] F_NONE  = 4'b0000;
    localparam logic [3:0] F_LAST  = 4'b0001;
    localparam logic [3:0] F_FIRST = 4'b0010;
    localparam logic [3:0] F_SUB   = 4'b0100;
    localparam logic [3:0] F_Q16   = 4'b1000;
    localparam logic [3:0] F_ONLY  = 4'b0011;

    typedef struct packed {
        asrc_t  asrc;
        vaddr_t addr_a;
        bsrc_t  bsrc;
        vaddr_t addr_b;
        logic   q16;
        logic   sub;
        logic   first;
        logic   last;
        vaddr_t dest;
    } ustep_t;

    function automatic ustep_t mk(input asrc_t a, input vaddr_t ra, input bsrc_t b,
                                  input vaddr_t rb, input logic [3:0] fl,
                                  input vaddr_t d);
        ustep_t st;
        st.asrc   = a;
        st.addr_a = ra;
        st.bsrc   = b;
        st.addr_b = rb;
        st.q16    = fl[3];
        st.sub    = fl[2];
        st.first  = fl[1];
        st.last   = fl[0];
        st.dest   = d;
        return st;
    endfunction

    // One product per step; a group of steps accumulates into one element.
    function automatic ustep_t ustep(input step_t idx);
        ustep_t st;
        case (idx)
            // predicted state
            6'd0:  st = mk(AS_B0, V_EST0, BS_U,   V_EST0, F_FIRST, V_XP0);
            6'd1:  st = mk(AS_A0, V_EST0, BS_MEM, V_EST0, F_NONE,  V_XP0);
            6'd2:  st = mk(AS_A1, V_EST0, BS_MEM, V_EST1, F_LAST,  V_XP0);
            6'd3:  st = mk(AS_B1, V_EST0, BS_U,   V_EST0, F_FIRST, V_XP1);
            6'd4:  st = mk(AS_A2, V_EST0, BS_MEM, V_EST0, F_NONE,  V_XP1);
            6'd5:  st = mk(AS_A3, V_EST0, BS_MEM, V_EST1, F_LAST,  V_XP1);
            // A P
            6'd6:  st = mk(AS_A0, V_EST0, BS_MEM, V_COV0, F_FIRST, V_AP0);
            6'd7:  st = mk(AS_A1, V_EST0, BS_MEM, V_COV2, F_LAST,  V_AP0);
            6'd8:  st = mk(AS_A0, V_EST0, BS_MEM, V_COV1, F_FIRST, V_AP1);
            6'd9:  st = mk(AS_A1, V_EST0, BS_MEM, V_COV3, F_LAST,  V_AP1);
            6'd10: st = mk(AS_A2, V_EST0, BS_MEM, V_COV0, F_FIRST, V_AP2);
            6'd11: st = mk(AS_A3, V_EST0, BS_MEM, V_COV2, F_LAST,  V_AP2);
            6'd12: st = mk(AS_A2, V_EST0, BS_MEM, V_COV1, F_FIRST, V_AP3);
            6'd13: st = mk(AS_A3, V_EST0, BS_MEM, V_COV3, F_LAST,  V_AP3);
            // predicted covariance, Q plus (A P) A'
            6'd14: st = mk(AS_Q0, V_EST0, BS_ONE, V_EST0, F_FIRST, V_PP0);
            6'd15: st = mk(AS_A0, V_EST0, BS_MEM, V_AP0,  F_NONE,  V_PP0);
            6'd16: st = mk(AS_A1, V_EST0, BS_MEM, V_AP1,  F_LAST,  V_PP0);
            6'd17: st = mk(AS_Q1, V_EST0, BS_ONE, V_EST0, F_FIRST, V_PP1);
            6'd18: st = mk(AS_A2, V_EST0, BS_MEM, V_AP0,  F_NONE,  V_PP1);
            6'd19: st = mk(AS_A3, V_EST0, BS_MEM, V_AP1,  F_LAST,  V_PP1);
            6'd20: st = mk(AS_Q2, V_EST0, BS_ONE, V_EST0, F_FIRST, V_PP2);
            6'd21: st = mk(AS_A0, V_EST0, BS_MEM, V_AP2,  F_NONE,  V_PP2);
            6'd22: st = mk(AS_A1, V_EST0, BS_MEM, V_AP3,  F_LAST,  V_PP2);
            6'd23: st = mk(AS_Q3, V_EST0, BS_ONE, V_EST0, F_FIRST, V_PP3);
            6'd24: st = mk(AS_A2, V_EST0, BS_MEM, V_AP2,  F_NONE,  V_PP3);
            6'd25: st = mk(AS_A3, V_EST0, BS_MEM, V_AP3,  F_LAST,  V_PP3);
            // P C'
            6'd26: st = mk(AS_C0, V_EST0, BS_MEM, V_PP0,  F_FIRST, V_PC0);
            6'd27: st = mk(AS_C1, V_EST0, BS_MEM, V_PP1,  F_LAST,  V_PC0);
            6'd28: st = mk(AS_C0, V_EST0, BS_MEM, V_PP2,  F_FIRST, V_PC1);
            6'd29: st = mk(AS_C1, V_EST0, BS_MEM, V_PP3,  F_LAST,  V_PC1);
            // innovation covariance
            6'd30: st = mk(AS_R,  V_EST0, BS_ONE, V_EST0, F_FIRST, V_S);
            6'd31: st = mk(AS_C0, V_EST0, BS_MEM, V_PC0,  F_NONE,  V_S);
            6'd32: st = mk(AS_C1, V_EST0, BS_MEM, V_PC1,  F_LAST,  V_S);
            // gain
            6'd33: st = mk(AS_MEM, V_PC0, BS_MEM, V_INV, F_Q16 | F_ONLY, V_K0);
            6'd34: st = mk(AS_MEM, V_PC1, BS_MEM, V_INV, F_Q16 | F_ONLY, V_K1);
            // innovation
            6'd35: st = mk(AS_UNIT, V_EST0, BS_Y,   V_EST0, F_FIRST,        V_INNOV);
            6'd36: st = mk(AS_C0,   V_EST0, BS_MEM, V_XP0,  F_SUB,          V_INNOV);
            6'd37: st = mk(AS_C1,   V_EST0, BS_MEM, V_XP1,  F_SUB | F_LAST, V_INNOV);
            // corrected state
            6'd38: st = mk(AS_UNIT, V_EST0, BS_MEM, V_XP0,   F_FIRST,        V_EST0);
            6'd39: st = mk(AS_MEM,  V_K0,   BS_MEM, V_INNOV, F_Q16 | F_LAST, V_EST0);
            6'd40: st = mk(AS_UNIT, V_EST0, BS_MEM, V_XP1,   F_FIRST,        V_EST1);
            6'd41: st = mk(AS_MEM,  V_K1,   BS_MEM, V_INNOV, F_Q16 | F_LAST, V_EST1);
            // I - K C
            6'd42: st = mk(AS_UNIT, V_EST0, BS_ONE, V_EST0, F_FIRST,        V_M0);
            6'd43: st = mk(AS_C0,   V_EST0, BS_MEM, V_K0,   F_SUB | F_LAST, V_M0);
            6'd44: st = mk(AS_C1,   V_EST0, BS_MEM, V_K0,   F_SUB | F_ONLY, V_M1);
            6'd45: st = mk(AS_C0,   V_EST0, BS_MEM, V_K1,   F_SUB | F_ONLY, V_M2);
            6'd46: st = mk(AS_UNIT, V_EST0, BS_ONE, V_EST0, F_FIRST,        V_M3);
            6'd47: st = mk(AS_C1,   V_EST0, BS_MEM, V_K1,   F_SUB | F_LAST, V_M3);
            // corrected covariance
            6'd48: st = mk(AS_MEM, V_M0, BS_MEM, V_PP0, F_Q16 | F_FIRST, V_COV0);
            6'd49: st = mk(AS_MEM, V_M1, BS_MEM, V_PP2, F_Q16 | F_LAST,  V_COV0);
            6'd50: st = mk(AS_MEM, V_M0, BS_MEM, V_PP1, F_Q16 | F_FIRST, V_COV1);
            6'd51: st = mk(AS_MEM, V_M1, BS_MEM, V_PP3, F_Q16 | F_LAST,  V_COV1);
            6'd52: st = mk(AS_MEM, V_M2, BS_MEM, V_PP0, F_Q16 | F_FIRST, V_COV2);
            6'd53: st = mk(AS_MEM, V_M3, BS_MEM, V_PP2, F_Q16 | F_LAST,  V_COV2);
            6'd54: st = mk(AS_MEM, V_M2, BS_MEM, V_PP1, F_Q16 | F_FIRST, V_COV3);
            6'd55: st = mk(AS_MEM, V_M3, BS_MEM, V_PP3, F_Q16 | F_LAST,  V_COV3);
            default: st = mk(AS_UNIT, V_EST0, BS_ONE, V_EST0, F_ONLY, V_S);
        endcase
        return st;
    endfunction

    // Signed Q4.12 entry k of a packed 64-bit register, as 32 bits.
    function automatic logic signed [31:0] coef(input logic [63:0] r, input logic [1:0] k);
        logic [15:0] raw;
        raw = r[16*k +: 16];
        return {{16{raw[15]}}, raw};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [31:0] res;
        if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]))
            res = v[31:0];
        else if (v[ACC_W-1])
            res = 32'h80000000;
        else
            res = 32'h7FFFFFFF;
        return res;
    endfunction

endpackage

FILE: hw/rtl/kalman_filter_step.sv
// ----------------------------------------------------------------------------
// kalman_filter_step
// Two-state, one-measurement fixed-point Kalman filter step.
// ----------------------------------------------------------------------------
// Takes one item at a time and holds in_stall high until its result has been
// taken. An init item makes six scratch writes, then gives the result. An
// update runs a 56-step microcode through one 32x32 multiplier
// (read, multiply, accumulate per step, plus one store per result element,
// 26 in all) and a restoring divider for the reciprocal of the innovation
// covariance. An update before init, and the no-op command, go straight to
// the result. Scratch values live in a 27-entry memory with two registered
// read ports and one write port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kalman_filter_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic signed [31:0]  start_time,
    input  logic signed [31:0]  init_state_a,
    input  logic signed [31:0]  init_state_b,
    input  logic signed [31:0]  control_value,
    input  logic signed [31:0]  measured_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  estimate_a,
    output logic signed [31:0]  estimate_b,
    output logic signed [31:0]  current_time,
    output logic                not_ready
);
    import kf_pkg::*;

    // configuration
    logic [63:0] a_matrix_reg;
    logic [63:0] b_and_c_reg;
    logic [63:0] q_matrix_reg;
    logic [63:0] p_initial_reg;
    logic [14:0] r_noise_reg;
    logic [30:0] time_step_reg;

    state_t state_reg;
    state_t state_next;
    step_t  step_reg;
    step_t  step_next;
    logic [2:0] init_cnt_reg;
    logic       ready_reg;
    logic       not_ready_reg;

    logic [31:0] est_a_reg;
    logic [31:0] est_b_reg;
    logic [31:0] time_reg;
    logic [31:0] u_reg;
    logic [31:0] y_reg;

    logic [31:0] mem [MEM_DEPTH];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic        mem_we;
    vaddr_t      mem_waddr;
    logic [31:0] mem_wdata;

    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [32:0] div_num_reg;
    logic [31:0] div_rem_reg;
    logic [31:0] div_mag_reg;
    logic [32:0] div_quo_reg;
    logic [5:0]  div_cnt_reg;
    logic        s_neg_reg;
    logic        s_zero_reg;

    ustep_t cur;
    cmd_t   cmd;
    logic   in_accept;
    logic   out_accept;

    logic signed [31:0]      opa;
    logic signed [31:0]      opb;
    logic signed [63:0]      rnd;
    logic signed [63:0]      shifted;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_next;
    logic [31:0]             acc_sat;
    logic [31:0]             s_mag;
    logic [32:0]             div_sh;
    logic [32:0]             div_diff;
    logic                    div_ge;
    logic [31:0]             recip;
    logic [31:0]             inv_val;
    logic [1:0]              init_k;
    logic [32:0]             time_sum;
    logic [15:0]             p_raw;

    assign cur        = ustep(step_reg);
    assign cmd        = cmd_t'(command);
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (state_reg == ST_OUT);
    assign out_accept = out_valid && !out_stall;

    assign estimate_a   = est_a_reg;
    assign estimate_b   = est_b_reg;
    assign current_time = time_reg;
    assign not_ready    = not_ready_reg;

    // shared multiplier operands
    always_comb
    begin
        case (cur.asrc)
            AS_A0:   opa = coef(a_matrix_reg, 2'd0);
            AS_A1:   opa = coef(a_matrix_reg, 2'd1);
            AS_A2:   opa = coef(a_matrix_reg, 2'd2);
            AS_A3:   opa = coef(a_matrix_reg, 2'd3);
            AS_B0:   opa = coef(b_and_c_reg, 2'd0);
            AS_B1:   opa = coef(b_and_c_reg, 2'd1);
            AS_C0:   opa = coef(b_and_c_reg, 2'd2);
            AS_C1:   opa = coef(b_and_c_reg, 2'd3);
            AS_Q0:   opa = coef(q_matrix_reg, 2'd0);
            AS_Q1:   opa = coef(q_matrix_reg, 2'd1);
            AS_Q2:   opa = coef(q_matrix_reg, 2'd2);
            AS_Q3:   opa = coef(q_matrix_reg, 2'd3);
            AS_R:    opa = {17'd0, r_noise_reg};
            AS_UNIT: opa = 32'sd4096;
            AS_MEM:  opa = rd_a_reg;
            default: opa = 32'sd0;
        endcase
        case (cur.bsrc)
            BS_MEM:  opb = rd_b_reg;
            BS_U:    opb = u_reg;
            BS_Y:    opb = y_reg;
            BS_ONE:  opb = 32'sd65536;
            default: opb = 32'sd0;
        endcase
    end

    // round half up, then scale back to Q16.16
    always_comb
    begin
        rnd     = prod_reg + (cur.q16 ? 64'sd32768 : 64'sd2048);
        shifted = cur.q16 ? (rnd >>> 16) : (rnd >>> 12);
        term    = shifted[ACC_W-1:0];
        if (cur.first)
            acc_next = cur.sub ? -term : term;
        else
            acc_next = cur.sub ? (acc_reg - term) : (acc_reg + term);
    end

    assign acc_sat = sat32(acc_reg);
    assign s_mag   = acc_sat[31] ? (32'd0 - acc_sat) : acc_sat;

    // restoring division, one quotient bit per cycle
    assign div_sh   = {div_rem_reg, div_num_reg[32]};
    assign div_diff = div_sh - {1'b0, div_mag_reg};
    assign div_ge   = (div_sh >= {1'b0, div_mag_reg});
    assign recip    = (div_quo_reg[32:31] != 2'b00) ? 32'h7FFFFFFF : div_quo_reg[31:0];
    assign inv_val  = s_zero_reg ? 32'd0 : (s_neg_reg ? (32'd0 - recip) : recip);

    assign init_k   = 2'(init_cnt_reg - 3'd2);
    assign p_raw    = p_initial_reg[16*init_k +: 16];
    assign time_sum = {time_reg[31], time_reg} + {2'b00, time_step_reg};

    // scratch write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = V_EST0;
        mem_wdata = 32'd0;
        case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
                if (init_cnt_reg == 3'd0)
                begin
                    mem_waddr = V_EST0;
                    mem_wdata = est_a_reg;
                end
                else if (init_cnt_reg == 3'd1)
                begin
                    mem_waddr = V_EST1;
                    mem_wdata = est_b_reg;
                end
                else
                begin
                    mem_waddr = V_COV0 + vaddr_t'(init_k);
                    mem_wdata = {{12{p_raw[15]}}, p_raw, 4'b0000};
                end
            end
            ST_STORE:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur.dest;
                mem_wdata = acc_sat;
            end
            ST_INV:
            begin
                mem_we    = 1'b1;
                mem_waddr = V_INV;
                mem_wdata = inv_val;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_a_reg <= mem[cur.addr_a];
        rd_b_reg <= mem[cur.addr_b];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    step_next = '0;
                    if (cmd == CMD_INIT_FIELDS || cmd == CMD_INIT_ZERO)
                        state_next = ST_INIT;
                    else if (cmd == CMD_UPDATE && ready_reg)
                        state_next = ST_READ;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_INIT:
            begin
                if (init_cnt_reg == 3'd5)
                    state_next = ST_OUT;
            end
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:
            begin
                if (cur.last)
                    state_next = ST_STORE;
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_STORE:
            begin
                step_next = step_reg + 1'b1;
                if (cur.dest == V_S)
                    state_next = ST_DIV;
                else if (step_reg == LAST_STEP)
                    state_next = ST_OUT;
                else
                    state_next = ST_READ;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 6'd0)
                    state_next = ST_INV;
            end
            ST_INV:   state_next = ST_READ;
            ST_OUT:
            begin
                if (out_accept)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_matrix_reg  <= '0;
            b_and_c_reg   <= '0;
            q_matrix_reg  <= '0;
            p_initial_reg <= '0;
            r_noise_reg   <= '0;
            time_step_reg <= '0;
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            init_cnt_reg  <= '0;
            ready_reg     <= 1'b0;
            not_ready_reg <= 1'b0;
            est_a_reg     <= '0;
            est_b_reg     <= '0;
            time_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_A_MATRIX:  a_matrix_reg  <= cfg_data;
                    CFG_B_AND_C:   b_and_c_reg   <= cfg_data;
                    CFG_Q_MATRIX:  q_matrix_reg  <= cfg_data;
                    CFG_P_INITIAL: p_initial_reg <= cfg_data;
                    CFG_R_NOISE:   r_noise_reg   <= cfg_data[14:0];
                    CFG_TIME_STEP: time_step_reg <= cfg_data[30:0];
                    default:       ;
                endcase
            end

            if (in_accept)
            begin
                init_cnt_reg  <= '0;
                not_ready_reg <= (cmd == CMD_UPDATE) && !ready_reg;
                if (cmd == CMD_INIT_FIELDS)
                begin
                    est_a_reg <= init_state_a;
                    est_b_reg <= init_state_b;
                    time_reg  <= start_time;
                    ready_reg <= 1'b1;
                end
                else if (cmd == CMD_INIT_ZERO)
                begin
                    est_a_reg <= '0;
                    est_b_reg <= '0;
                    time_reg  <= '0;
                    ready_reg <= 1'b1;
                end
            end

            if (state_reg == ST_INIT)
                init_cnt_reg <= init_cnt_reg + 1'b1;

            if (state_reg == ST_STORE)
            begin
                if (cur.dest == V_EST0)
                    est_a_reg <= acc_sat;
                if (cur.dest == V_EST1)
                    est_b_reg <= acc_sat;
                // time advances once the last element is stored
                if (step_reg == LAST_STEP)
                    time_reg <= (time_sum[32:31] == 2'b01) ? 32'h7FFFFFFF : time_sum[31:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            u_reg <= control_value;
            y_reg <= measured_value;
        end
        if (state_reg == ST_MUL)
            prod_reg <= opa * opb;
        if (state_reg == ST_ACC)
            acc_reg <= acc_next;
        if (state_reg == ST_STORE && cur.dest == V_S)
        begin
            s_neg_reg   <= acc_sat[31];
            s_zero_reg  <= (acc_sat == 32'd0);
            div_mag_reg <= s_mag;
            div_num_reg <= {1'b1, 1'b0, s_mag[31:1]};
            div_rem_reg <= '0;
            div_quo_reg <= '0;
            div_cnt_reg <= 6'd32;
        end
        if (state_reg == ST_DIV)
        begin
            div_rem_reg <= div_ge ? div_diff[31:0] : div_sh[31:0];
            div_num_reg <= {div_num_reg[31:0], 1'b0};
            div_quo_reg <= {div_quo_reg[31:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    `KF_ASSERT_SAME(a_no_accept_busy, out_valid, in_stall)
    `KF_ASSERT_NEXT(a_div_follows_s, state_reg == ST_STORE && cur.dest == V_S, state_reg == ST_DIV)
    `KF_ASSERT_SAME(a_step_range, state_reg == ST_READ, step_reg <= LAST_STEP)
    `KF_ASSERT_SAME(a_not_ready_flag, out_valid && not_ready_reg, !ready_reg)

endmodule
